// File: rtl/tre_pkg.sv
// Shared types and constants for the rate one-third turbo encoder.
`default_nettype none

package tre_pkg;

	localparam int CODER_BITS = 4;
	localparam int PERM_W     = 10;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic              command;
		logic              data_bit;
		logic [PERM_W-1:0] perm_index;
		logic              last;
	} in_beat_t;

	typedef struct packed {
		logic sys_bit;
		logic parity1;
		logic parity2;
		logic last_out;
	} out_beat_t;

	typedef struct packed {
		logic step;
		logic clear;
	} coder_ctl_t;

endpackage

`default_nettype wire

// File: rtl/tre_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module tre_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/tre_coder.sv
// One 16-state recursive systematic coder: state register and parity output.
`default_nettype none

module tre_coder
	import tre_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire coder_ctl_t ctl,
	input  wire logic       u,
	output logic            parity
);

	logic [CODER_BITS-1:0] state_q;
	logic [CODER_BITS-1:0] state_next;

	always_comb begin
		parity     = u ^ state_q[0] ^ state_q[1] ^ state_q[2];
		state_next = {state_q[2:0], u ^ state_q[0] ^ state_q[3]};
	end

	// clear wins: the final step of a block still emits parity from the old state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (ctl.clear) begin
			state_q <= '0;
		end else if (ctl.step) begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

// File: rtl/turbo_encoder_rate_third_core.sv
// Top level of the rate one-third turbo encoder: block stores, control and coders.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  in      | input     | in_valid / in_ready | in_data  (load bit or drain)
//  out     | output    | out_valid/out_ready | out_data (sys, p1, p2, last)
//
// A load's block RAM writes happen at the accepting edge.
// A drain reads both RAMs at the accepting edge; the coder step and output
// register load follow in the next cycle, while in_ready is held low by pend_s1.
// Reset clears control and coder state only; the RAMs need no clearing pass.
// A full output register stalls drain beats only; loads and ignored beats pass.
`default_nettype none

module turbo_encoder_rate_third_core
	import tre_pkg::*;
#(
	parameter int MAX_BLOCK = 1024
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_beat_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_beat_t      out_data
);

	localparam int AW  = $clog2(MAX_BLOCK);
	localparam int LW  = $clog2(MAX_BLOCK + 1);
	localparam int PW  = ((AW > PERM_W) ? AW : PERM_W) + 1;

	logic          draining_q;
	logic [LW-1:0] block_len_q;
	logic [LW-1:0] read_pos_q;
	logic          pend_s1;
	logic          fin_s1;
	logic          out_valid_q;
	out_beat_t     out_data_q;

	logic          out_free;
	logic          accept;
	logic          load_go;
	logic          drain_go;
	logic          store_ok;
	logic [PW-1:0] perm_w;
	logic          perm_ok;
	logic          fin_now;
	logic          nat_bit;
	logic          ilv_bit;
	logic          par1;
	logic          par2;
	coder_ctl_t    coder_ctl;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		in_ready = !pend_s1 &&
			(in_data.command == CMD_LOAD || !draining_q || out_free);
		accept   = in_valid && in_ready;
		load_go  = accept && in_data.command == CMD_LOAD && !draining_q;
		drain_go = accept && in_data.command == CMD_DRAIN && draining_q;
		store_ok = block_len_q < LW'(MAX_BLOCK);
		perm_w   = PW'(in_data.perm_index);
		perm_ok  = perm_w < PW'(MAX_BLOCK);
		fin_now  = ({1'b0, read_pos_q} + (LW+1)'(1)) >= {1'b0, block_len_q};
		coder_ctl.step  = pend_s1;
		coder_ctl.clear = (load_go && in_data.last) || (pend_s1 && fin_s1);
	end

	tre_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BLOCK)
	) u_nat_ram (
		.clk   (clk),
		.we    (load_go && store_ok),
		.waddr (block_len_q[AW-1:0]),
		.wdata (in_data.data_bit),
		.re    (drain_go),
		.raddr (read_pos_q[AW-1:0]),
		.rdata (nat_bit)
	);

	tre_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BLOCK)
	) u_ilv_ram (
		.clk   (clk),
		.we    (load_go && store_ok && perm_ok),
		.waddr (perm_w[AW-1:0]),
		.wdata (in_data.data_bit),
		.re    (drain_go),
		.raddr (read_pos_q[AW-1:0]),
		.rdata (ilv_bit)
	);

	tre_coder u_coder1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (coder_ctl),
		.u      (nat_bit),
		.parity (par1)
	);

	tre_coder u_coder2 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (coder_ctl),
		.u      (ilv_bit),
		.parity (par2)
	);

	// block control: positions advance at the accepting edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q  <= 1'b0;
			block_len_q <= '0;
			read_pos_q  <= '0;
			pend_s1     <= 1'b0;
		end else begin
			pend_s1 <= drain_go;
			if (load_go) begin
				if (store_ok) begin
					block_len_q <= block_len_q + LW'(1);
				end
				if (in_data.last) begin
					draining_q <= 1'b1;
					read_pos_q <= '0;
				end
			end
			if (drain_go) begin
				if (fin_now) begin
					draining_q  <= 1'b0;
					block_len_q <= '0;
					read_pos_q  <= '0;
				end else begin
					read_pos_q <= read_pos_q + LW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_go) begin
			fin_s1 <= fin_now;
		end
		if (pend_s1) begin
			out_data_q.sys_bit  <= nat_bit;
			out_data_q.parity1  <= par1;
			out_data_q.parity2  <= par2;
			out_data_q.last_out <= fin_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	a_s1_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !in_ready)
		else $error("input accepted while a drain read is in flight");

	a_s1_output_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q)
		else $error("drain result would overwrite a pending beat");

	a_pos_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> (read_pos_q < block_len_q))
		else $error("read position outside the loaded block");

	a_fin_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && fin_s1) |-> (!draining_q && block_len_q == '0))
		else $error("final triple did not close the block");
`endif

endmodule

`default_nettype wire
